/* rtl/core/dbmh_pkg.sv */
// Shared widths and register indexes for the dwell bin max hold block.
package dbmh_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned MaxW    = 31;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSettleVectors = 8'd0,
    CfgDwellVectors  = 8'd1
  } cfg_idx_e;

endpackage

/* rtl/core/dwell_bin_max_hold_top.sv */
// Per-bin spectrum maximum hold over dwell windows, with a one-entry-per-bin memory.
//
// Usage:
//   Bin samples enter on the in_* channel (valid/ready), one signed Q16.16
//   sample per item; every NUM_BINS items form one vector. The block discards
//   settle_vectors vectors, then gathers per-bin maxima (floored at zero) over
//   dwell_vectors vectors. During the last dwell vector one result item per bin
//   leaves on the out_* channel with the bin's index, its final maximum and
//   last_bin set on the final bin. Other input items cause no result.
//   Registers are written on the cfg_* channel, which is always ready; write
//   them only while the block is idle.
// Throughput and pipeline:
//   One item per cycle sustained unless a reporting item stalls. The maxima
//   memory is read as an item is accepted into the compare stage, and a reporting
//   item's compare result then goes into the output register and is offered. The
//   memory is written when an item leaves the compare stage; a read of the same
//   bin in that cycle takes the forwarded value instead of the stale memory word.
// Reset:
//   Settle phase, zero settle count, bin position zero. The maxima memory is not
//   cleared: the first dwell vector overwrites every entry before any read is used.
// Backpressure:
//   When out_ready_i is low the output register holds its item. A reporting item
//   in the compare stage holds behind it and in_ready_o drops until the output
//   register frees; items that report nothing keep flowing.
module dwell_bin_max_hold_top #(
  parameter int unsigned NUM_BINS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dbmh_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dbmh_pkg::CountW-1:0]         cfg_data_i,
  // sample input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [dbmh_pkg::ValueW-1:0]  in_bin_value_i,
  // result output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dbmh_pkg::IndexW-1:0]         out_bin_index_o,
  output logic [dbmh_pkg::MaxW-1:0]           out_bin_max_o,
  output logic                                out_last_bin_o
);

  localparam int unsigned PosW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(NUM_BINS - 1);

  localparam int unsigned CntW = dbmh_pkg::CountW;
  localparam int unsigned MaxW = dbmh_pkg::MaxW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] settle_vectors_q;
  logic [CntW-1:0] dwell_vectors_q;
  logic            cfg_wr;
  logic            cfg_wr_settle;
  logic            cfg_wr_dwell;

  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i && cfg_ready_o;
  assign cfg_wr_settle = cfg_wr && (cfg_index_i == dbmh_pkg::CfgSettleVectors);
  assign cfg_wr_dwell  = cfg_wr && (cfg_index_i == dbmh_pkg::CfgDwellVectors);

  // ---------------------------------------------------------------------------
  // Phase control, evaluated for the item being accepted
  // ---------------------------------------------------------------------------
  logic            in_dwell_q;
  logic            first_q;
  logic [CntW-1:0] vectors_left_q;
  logic [PosW-1:0] pos_q;

  logic            in_acc;
  logic            end_of_vec;
  logic            enter_dwell;
  logic            cur_dwell;
  logic            cur_first;
  logic [CntW-1:0] cur_left;
  logic [CntW-1:0] dec_left;
  logic            cur_emit;

  always_comb begin
    end_of_vec  = (pos_q == LastPos);
    enter_dwell = (pos_q == '0) && !in_dwell_q && (vectors_left_q == '0);
    cur_dwell   = in_dwell_q || enter_dwell;
    cur_first   = enter_dwell ? 1'b1 : first_q;
    if (enter_dwell) begin
      cur_left = (dwell_vectors_q != '0) ? dwell_vectors_q : CntW'(1);
    end else begin
      cur_left = vectors_left_q;
    end
    dec_left = (cur_left != '0) ? (cur_left - CntW'(1)) : cur_left;
    cur_emit = cur_dwell && (cur_left == CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_vectors_q <= '0;
      dwell_vectors_q  <= CntW'(1);
      in_dwell_q       <= 1'b0;
      first_q          <= 1'b1;
      vectors_left_q   <= '0;
      pos_q            <= '0;
    end else begin
      if (in_acc) begin
        if (end_of_vec) begin
          pos_q <= '0;
          if (cur_dwell) begin
            first_q <= 1'b0;
            if (dec_left == '0) begin
              // window done: back to settle with a fresh count
              in_dwell_q     <= 1'b0;
              vectors_left_q <= settle_vectors_q;
            end else begin
              in_dwell_q     <= 1'b1;
              vectors_left_q <= dec_left;
            end
          end else begin
            in_dwell_q     <= 1'b0;
            vectors_left_q <= dec_left;
          end
        end else begin
          pos_q          <= pos_q + PosW'(1);
          in_dwell_q     <= cur_dwell;
          vectors_left_q <= cur_left;
          first_q        <= cur_first;
        end
      end
      if (cfg_wr_settle) begin
        settle_vectors_q <= cfg_data_i;
        // restart the settle count while settling
        if (!in_dwell_q) begin
          vectors_left_q <= cfg_data_i;
        end
      end
      if (cfg_wr_dwell) begin
        dwell_vectors_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Compare stage (s1) and output register
  // ---------------------------------------------------------------------------
  logic                              s1_valid_q;
  logic                              s1_dwell_q;
  logic                              s1_first_q;
  logic                              s1_emit_q;
  logic                              s1_last_q;
  logic [PosW-1:0]                   s1_pos_q;
  logic signed [dbmh_pkg::ValueW-1:0] s1_value_q;
  logic                              fwd_q;
  logic [MaxW-1:0]                   fwd_data_q;
  logic [MaxW-1:0]                   rdata_q;

  logic                              s1_adv;
  logic                              mem_we;
  logic [MaxW-1:0]                   prev_max;
  logic [MaxW-1:0]                   new_max;

  logic                              out_valid_q;
  logic [dbmh_pkg::IndexW-1:0]       out_index_q;
  logic [MaxW-1:0]                   out_max_q;
  logic                              out_last_q;

  // a non-reporting item never waits on the output register
  assign s1_adv = s1_valid_q && (!s1_emit_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc = in_valid_i && in_ready_o;
  assign mem_we = s1_adv && s1_dwell_q;

  always_comb begin
    if (s1_first_q) begin
      prev_max = '0;
    end else if (fwd_q) begin
      prev_max = fwd_data_q;
    end else begin
      prev_max = rdata_q;
    end
    if (s1_value_q > $signed({1'b0, prev_max})) begin
      new_max = s1_value_q[MaxW-1:0];
    end else begin
      new_max = prev_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_dwell_q <= cur_dwell;
      s1_first_q <= cur_first;
      s1_emit_q  <= cur_emit;
      s1_last_q  <= end_of_vec;
      s1_pos_q   <= pos_q;
      s1_value_q <= in_bin_value_i;
      // the memory read below misses a write to the same bin in this cycle
      fwd_q      <= mem_we && (s1_pos_q == pos_q);
      fwd_data_q <= new_max;
    end
    if (s1_adv && s1_emit_q) begin
      out_index_q <= dbmh_pkg::IndexW'(s1_pos_q);
      out_max_q   <= new_max;
      out_last_q  <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Maxima memory: one read port at accept, one write port at s1 exit
  // ---------------------------------------------------------------------------
  logic [MaxW-1:0] maxima_mem [NUM_BINS];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      maxima_mem[s1_pos_q] <= new_max;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= maxima_mem[pos_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_bin_index_o = out_index_q;
  assign out_bin_max_o   = out_max_q;
  assign out_last_bin_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_on_final_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_bin_o |-> out_bin_index_o == dbmh_pkg::IndexW'(NUM_BINS - 1))
    else $error("last_bin flagged on a bin other than the final one");

  a_emit_only_in_dwell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q |-> s1_dwell_q)
    else $error("report item outside the dwell phase");

  a_dwell_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_dwell_q |-> vectors_left_q != '0)
    else $error("dwell phase with an exhausted vector count");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the compare stage is stalled");

endmodule
